// File: rtl/json_esc_pkg.sv
// ----------------------------------------------------------------------------
// JSON string escaper package
// Character codes, sizes and the hex digit lookup shared by the escaper.
// ----------------------------------------------------------------------------
package json_esc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 16;
    localparam int unsigned MAX_SEQ   = 6;   // longest escape: \u00XY
    localparam int unsigned LEN_W     = 3;   // holds 0..MAX_SEQ

    localparam logic [POS_W-1:0]  CAP_RESET = 16'd256;

    localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_DEL       = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_U         = 8'h75;
    localparam logic [BYTE_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_A         = 8'h61;

    localparam logic [LEN_W-1:0]  LEN_PLAIN  = 3'd1;
    localparam logic [LEN_W-1:0]  LEN_SHORT  = 3'd2;
    localparam logic [LEN_W-1:0]  LEN_UNICODE = 3'd6;

    // Lower-case hex digit for one nibble
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_A + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

// File: rtl/json_string_escaper.sv
// ----------------------------------------------------------------------------
// JSON string escaper
// Escapes a zero-terminated byte stream for use inside a JSON string and
// tracks the output buffer fill against a configured capacity.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                         Contents
//  s         in         i_s_tvalid/o_s_tready/i_s_tdata  char_byte
//  m         out        o_m_tvalid/i_m_tready/o_m_tdata  out_byte, out_position
//                       o_m_tlast, o_m_tuser             end_of_string, failed
//  cfg       in         i_cfg_wr_en/i_cfg_wr_data        out_capacity
//
//  Output: a plain byte gives 1 byte, a quote or backslash 2, a control byte 6
//  (one output transaction per cycle from the sequence buffer, unless stalled).
//  A new input transaction is taken while the final byte of the previous one is
//  taken, so unstalled plain text flows at one byte per cycle; dropped bytes give no output.
//  Reset (synchronous, active low) empties the buffer, clears the fill count
//  and the drop flag and sets the capacity to 256.
//  A stall on the master side holds the current byte and stops input.
// ----------------------------------------------------------------------------
module json_string_escaper (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] char_byte

    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,      // [7:0] out_byte, [23:8] out_position
    output logic        o_m_tlast,      // end_of_string
    output logic        o_m_tuser,      // failed

    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data   // out_capacity
);

    localparam int unsigned BW = json_esc_pkg::BYTE_W;
    localparam int unsigned PW = json_esc_pkg::POS_W;
    localparam int unsigned NS = json_esc_pkg::MAX_SEQ;
    localparam int unsigned LW = json_esc_pkg::LEN_W;

    // Control and buffer state
    logic [PW-1:0] r_capacity;
    logic [PW-1:0] r_written;          // bytes written for the current string
    logic          r_discard;          // overflow seen, dropping to terminator
    logic [LW-1:0] r_cnt;              // bytes left in the sequence buffer
    logic [BW-1:0] r_seq [NS];         // pending bytes, head at index 0
    logic [PW-1:0] r_pos;              // buffer position of the head byte
    logic          r_last;
    logic          r_fail;

    logic [PW-1:0] n_capacity;
    logic [PW-1:0] n_written;
    logic          n_discard;
    logic [LW-1:0] n_cnt;
    logic [BW-1:0] n_seq [NS];
    logic [PW-1:0] n_pos;
    logic          n_last;
    logic          n_fail;

    logic          s_accept;
    logic          m_take;
    logic [BW-1:0] ch;
    logic          is_short;
    logic          is_ctrl;
    logic [LW-1:0] esc_len;
    logic [PW:0]   fill_sum;
    logic          overflow;

    assign s_accept = i_s_tvalid & o_s_tready;
    assign m_take   = o_m_tvalid & i_m_tready;

    // Room for a new transaction once the buffer is empty or its last byte leaves
    assign o_s_tready = (r_cnt == '0) || ((r_cnt == LW'(1)) && i_m_tready);

    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = {r_pos, r_seq[0]};
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_fail;

    // Classify the incoming byte
    assign ch       = i_s_tdata;
    assign is_short = (ch == json_esc_pkg::CH_QUOTE) || (ch == json_esc_pkg::CH_BACKSLASH);
    assign is_ctrl  = (ch < json_esc_pkg::CH_SPACE) || (ch == json_esc_pkg::CH_DEL);

    always_comb begin
        if (is_short) begin
            esc_len = json_esc_pkg::LEN_SHORT;
        end else if (is_ctrl) begin
            esc_len = json_esc_pkg::LEN_UNICODE;
        end else begin
            esc_len = json_esc_pkg::LEN_PLAIN;
        end
    end

    // Always keep one byte free for the terminator
    assign fill_sum = {1'b0, r_written} + (PW+1)'(esc_len);
    assign overflow = (fill_sum >= {1'b0, r_capacity});

    always_comb begin
        n_capacity = i_cfg_wr_en ? i_cfg_wr_data : r_capacity;
        n_written  = r_written;
        n_discard  = r_discard;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_last     = r_last;
        n_fail     = r_fail;
        for (int i = 0; i < NS; i++) begin
            n_seq[i] = r_seq[i];
        end

        if (s_accept) begin
            n_last = 1'b0;
            n_fail = 1'b0;
            n_pos  = r_written;
            if (r_discard) begin
                // dropped, no output; the terminator ends the drop
                n_cnt = '0;
                if (ch == json_esc_pkg::CH_NUL) begin
                    n_discard = 1'b0;
                    n_written = '0;
                end
            end else if (ch == json_esc_pkg::CH_NUL) begin
                n_cnt     = LW'(1);
                n_seq[0]  = json_esc_pkg::CH_NUL;
                n_last    = 1'b1;
                n_written = '0;
            end else if (overflow) begin
                n_cnt     = LW'(1);
                n_seq[0]  = json_esc_pkg::CH_NUL;
                n_pos     = '0;
                n_last    = 1'b1;
                n_fail    = 1'b1;
                n_written = '0;
                n_discard = 1'b1;
            end else begin
                n_cnt     = esc_len;
                n_written = fill_sum[PW-1:0];
                if (is_short) begin
                    n_seq[0] = json_esc_pkg::CH_BACKSLASH;
                    n_seq[1] = ch;
                end else if (is_ctrl) begin
                    n_seq[0] = json_esc_pkg::CH_BACKSLASH;
                    n_seq[1] = json_esc_pkg::CH_U;
                    n_seq[2] = json_esc_pkg::CH_ZERO;
                    n_seq[3] = json_esc_pkg::CH_ZERO;
                    n_seq[4] = json_esc_pkg::hex_digit(ch[7:4]);
                    n_seq[5] = json_esc_pkg::hex_digit(ch[3:0]);
                end else begin
                    n_seq[0] = ch;
                end
            end
        end else if (m_take) begin
            // shift the next pending byte to the head
            n_cnt = r_cnt - LW'(1);
            n_pos = r_pos + PW'(1);
            for (int i = 0; i < NS - 1; i++) begin
                n_seq[i] = r_seq[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= json_esc_pkg::CAP_RESET;
            r_written  <= '0;
            r_discard  <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_capacity <= n_capacity;
            r_written  <= n_written;
            r_discard  <= n_discard;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_last <= n_last;
        r_fail <= n_fail;
        for (int i = 0; i < NS; i++) begin
            r_seq[i] <= n_seq[i];
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LW'(NS))
        else $error("sequence count out of range");

    a_last_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (r_cnt == LW'(1)))
        else $error("terminator not alone in buffer");

    a_fail_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && r_pos == '0))
        else $error("failure flag without terminator at position 0");

    a_drop_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_discard) |=> (r_cnt == '0))
        else $error("dropped byte produced output");

    a_fill_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !r_discard && !overflow) |=> (r_written < r_capacity))
        else $error("fill count reached capacity");
`endif

endmodule

// File: sim/json_escape_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON escaper scoreboard
// Watches the input, output and capacity ports, keeps its own copy of the
// fill count and drop flag, and checks every output transaction in order.
// ----------------------------------------------------------------------------
module json_escape_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,

    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_m_tuser,

    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,

    output int          o_fail_count,
    output int          o_pending,
    output int          o_live_bytes,   // input bytes taken outside the drop state
    output int          o_bytes_seen,
    output int          o_out_checked,
    output int          o_clean_ends,
    output int          o_overflows
);

    typedef struct packed {
        logic [json_esc_pkg::BYTE_W-1:0] out_byte;
        logic [json_esc_pkg::POS_W-1:0]  out_position;
        logic                            end_of_string;
        logic                            failed;
    } t_esc_out;

    localparam logic [8*16-1:0] HEX_TEXT = "0123456789abcdef";
    localparam int              LOUD_FAILS = 10;

    t_esc_out                       escaped_q[$];
    logic [json_esc_pkg::POS_W-1:0] capacity   = json_esc_pkg::CAP_RESET;
    logic [json_esc_pkg::POS_W-1:0] fill_count = '0;
    logic                           dropping   = 1'b0;

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        int idx;
        idx = 15 - int'(nib);
        return HEX_TEXT[8*idx +: 8];
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic [15:0] pos,
                              input logic eos, input logic fail);
        t_esc_out r;
        r.out_byte      = b;
        r.out_position  = pos;
        r.end_of_string = eos;
        r.failed        = fail;
        escaped_q.push_back(r);
    endtask

    // Expected output bytes for one accepted input byte
    task automatic escape_char(input logic [7:0] c);
        logic [7:0]  seq [json_esc_pkg::MAX_SEQ];
        int          n;
        logic [16:0] reach;
        if (dropping) begin
            if (c == json_esc_pkg::CH_NUL) begin
                dropping   = 1'b0;
                fill_count = '0;
            end
            return;
        end
        o_live_bytes++;
        if (c == json_esc_pkg::CH_NUL) begin
            queue_byte(json_esc_pkg::CH_NUL, fill_count, 1'b1, 1'b0);
            fill_count = '0;
            o_clean_ends++;
            return;
        end
        if (c == json_esc_pkg::CH_QUOTE || c == json_esc_pkg::CH_BACKSLASH) begin
            seq[0] = json_esc_pkg::CH_BACKSLASH;
            seq[1] = c;
            n = 2;
        end else if (c < json_esc_pkg::CH_SPACE || c == json_esc_pkg::CH_DEL) begin
            seq[0] = json_esc_pkg::CH_BACKSLASH;
            seq[1] = json_esc_pkg::CH_U;
            seq[2] = json_esc_pkg::CH_ZERO;
            seq[3] = json_esc_pkg::CH_ZERO;
            seq[4] = nibble_char(c[7:4]);
            seq[5] = nibble_char(c[3:0]);
            n = 6;
        end else begin
            seq[0] = c;
            n = 1;
        end
        // terminator room is always kept, hence >=
        reach = {1'b0, fill_count} + 17'(n);
        if (reach >= {1'b0, capacity}) begin
            queue_byte(json_esc_pkg::CH_NUL, '0, 1'b1, 1'b1);
            fill_count = '0;
            dropping   = 1'b1;
            o_overflows++;
            return;
        end
        for (int i = 0; i < n; i++) begin
            queue_byte(seq[i], fill_count + 16'(i), 1'b0, 1'b0);
        end
        fill_count = fill_count + 16'(n);
    endtask

    task automatic check_output();
        t_esc_out seen;
        t_esc_out want;
        seen.out_byte      = i_m_tdata[7:0];
        seen.out_position  = i_m_tdata[23:8];
        seen.end_of_string = i_m_tlast;
        seen.failed        = i_m_tuser;
        if (escaped_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= LOUD_FAILS) begin
                $display("[%0t] unexpected output: byte %02h pos %0d last %0b fail %0b",
                         $realtime, seen.out_byte, seen.out_position,
                         seen.end_of_string, seen.failed);
            end
            return;
        end
        want = escaped_q.pop_front();
        o_out_checked++;
        if (seen !== want) begin
            o_fail_count++;
            if (o_fail_count <= LOUD_FAILS) begin
                $display("[%0t] mismatch: want byte %02h pos %0d last %0b fail %0b",
                         $realtime, want.out_byte, want.out_position,
                         want.end_of_string, want.failed);
                $display("[%0t]           got  byte %02h pos %0d last %0b fail %0b",
                         $realtime, seen.out_byte, seen.out_position,
                         seen.end_of_string, seen.failed);
            end
        end
    endtask

    // Input pushed before output popped, so a same-edge pass-through still lines up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity   = json_esc_pkg::CAP_RESET;
            fill_count = '0;
            dropping   = 1'b0;
            escaped_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                capacity = i_cfg_wr_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                o_bytes_seen++;
                escape_char(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_output();
            end
        end
        o_pending = escaped_q.size();
    end

endmodule

// File: sim/tb_json_string_escaper.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string escaper testbench
// Drives zero-terminated strings into the escaper under several output
// capacities, with random gaps on both sides; a separate scoreboard predicts
// and checks every escaped byte, its position and the end/overflow flags.
// ----------------------------------------------------------------------------
module tb_json_string_escaper;

    localparam int TOTAL_BYTES   = 340;     // random phases stop once this many input bytes are seen
    localparam int SETTLE_CYCLES = 12;      // > longest escape (6 bytes) plus pipeline slack
    localparam int TIME_LIMIT_NS = 400_000;
    localparam int GAP_PERCENT   = 12;

    // Block ports; the inputs are driven to known values from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_s_tvalid    = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata     = '0;        // [7:0] char_byte
    logic        o_m_tvalid;
    logic        i_m_tready    = 1'b0;
    logic [23:0] o_m_tdata;                 // [7:0] out_byte, [23:8] out_position
    logic        o_m_tlast;                 // end_of_string
    logic        o_m_tuser;                 // failed
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;        // out_capacity

    // Both sides run without gaps while this is set
    logic        steady = 1'b0;

    int fail_count;
    int pending;
    int live_bytes;
    int bytes_seen;
    int out_checked;
    int clean_ends;
    int overflows;
    int cap_writes = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    json_string_escaper u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast),
        .o_m_tuser     (o_m_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    json_escape_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tlast     (o_m_tlast),
        .i_m_tuser     (o_m_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_live_bytes  (live_bytes),
        .o_bytes_seen  (bytes_seen),
        .o_out_checked (out_checked),
        .o_clean_ends  (clean_ends),
        .o_overflows   (overflows)
    );

    // Receiver: back-pressure on roughly one cycle in eight, none while steady
    always @(negedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(0, 99) >= GAP_PERCENT);
    end

    // Hard stop in case the block hangs
    initial begin
        #(TIME_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // One input transaction, with an optional random gap ahead of it.
    // Entered and left at a falling edge; tvalid stays high for back-to-back bytes.
    task automatic send_char(input logic [7:0] c);
        while (!steady && $urandom_range(0, 99) < GAP_PERCENT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Sender holds off until every predicted byte is out, then lets the
    // block settle: dropped bytes give no output to wait on.
    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Capacity only changes with the block idle (possibly mid-string)
    task automatic set_capacity(input logic [15:0] cap);
        i_s_tvalid <= 1'b0;
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cap_writes++;
    endtask

    // Mostly printable text, with a good share of every escape class
    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 8'($urandom_range(32, 126));
        end else if (roll < 60) begin
            return ($urandom_range(0, 1) != 0) ? json_esc_pkg::CH_QUOTE
                                               : json_esc_pkg::CH_BACKSLASH;
        end else if (roll < 72) begin
            return ($urandom_range(0, 7) == 0) ? json_esc_pkg::CH_DEL
                                               : 8'($urandom_range(1, 31));
        end else if (roll < 88) begin
            return 8'($urandom_range(128, 255));
        end
        return 8'($urandom_range(1, 255));
    endfunction

    // Small capacities dominate so overflow and the drop state get exercised
    function automatic logic [15:0] pick_capacity();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return 16'd1;
        end else if (roll < 18) begin
            return 16'hFFFF;
        end else if (roll < 28) begin
            return json_esc_pkg::CAP_RESET;
        end else if (roll < 45) begin
            return 16'($urandom_range(2, 8));
        end
        return 16'($urandom_range(2, 48));
    endfunction

    initial begin
        int phase;
        int strings;
        int len;
        logic [7:0] opening [12];

        opening = '{json_esc_pkg::CH_NUL, json_esc_pkg::CH_SPACE, 8'h41,
                    json_esc_pkg::CH_QUOTE, json_esc_pkg::CH_BACKSLASH, 8'h01,
                    8'h1F, json_esc_pkg::CH_DEL, 8'h7E, 8'h80, 8'hFF,
                    json_esc_pkg::CH_NUL};

        // Synchronous reset held low from time zero, released at a falling edge
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- Directed part ---------------------------------------------------
        // Reset capacity: empty string, then one of each byte class and the
        // class boundaries (0x1F/0x20, 0x7E/0x7F/0x80, 0xFF)
        foreach (opening[i]) send_char(opening[i]);

        // Capacity zero: any byte overflows, a bare terminator still succeeds
        set_capacity(16'd0);
        send_char(8'h78);
        send_char(json_esc_pkg::CH_NUL);
        send_char(json_esc_pkg::CH_NUL);

        // Capacity three: two plain bytes fit, the third hits the terminator slot,
        // terminator then only clears the drop state
        set_capacity(16'd3);
        send_char(8'h61);
        send_char(8'h62);
        send_char(8'h63);
        send_char(json_esc_pkg::CH_NUL);

        // Capacity lowered mid-string: next escape overflows
        set_capacity(16'd7);
        send_char(8'h61);
        send_char(json_esc_pkg::CH_QUOTE);
        set_capacity(16'd2);
        send_char(8'h1B);
        send_char(json_esc_pkg::CH_NUL);

        // Capacity lowered mid-string: terminator first still succeeds
        set_capacity(16'd7);
        send_char(8'h7A);
        set_capacity(16'd1);
        send_char(json_esc_pkg::CH_NUL);

        // --- Random part -----------------------------------------------------
        // Phases of one capacity each; the last string of a phase is sometimes
        // left open so the next capacity lands mid-string.
        i_s_tvalid <= 1'b0;
        wait_idle();
        phase = 0;
        while (bytes_seen < TOTAL_BYTES) begin
            if (phase == 0) begin
                set_capacity(16'hFFFF);
            end else if (phase == 1) begin
                set_capacity(16'd1);
            end else begin
                set_capacity(pick_capacity());
            end
            steady <= (phase >= 4 && phase < 9);
            strings = $urandom_range(1, 4);
            for (int s = 0; s < strings; s++) begin
                len = $urandom_range(0, 20);
                repeat (len) send_char(pick_char());
                if (s < strings - 1 || $urandom_range(0, 2) != 0) begin
                    send_char(json_esc_pkg::CH_NUL);
                end
            end
            phase++;
        end

        // --- Wind-down -------------------------------------------------------
        i_s_tvalid <= 1'b0;
        steady     <= 1'b0;
        wait_idle();

        $display("Covered %0d input bytes (%0d not dropped), %0d escaped bytes checked",
                 bytes_seen, live_bytes, out_checked);
        $display("Strings: %0d ended cleanly, %0d overflowed, over %0d capacity writes",
                 clean_ends, overflows, cap_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/json_esc_pkg.sv
rtl/json_string_escaper.sv
sim/json_escape_checker.sv
sim/tb_json_string_escaper.sv
